[rtl/gat_pkg.sv]
// Shared types, constants and saturating helpers for the geared angle tracker.
// Used by gat_iter_unit and geared_angle_tracker; no dependencies.
package gat_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int COUNT_W       = 48;
  localparam int GEAR_W        = 32;
  localparam int RAW_W         = 17;

  // One turn and half a turn in angle units
  localparam logic [31:0] FULL_TURN = 32'(360 << FRACTION_BITS);
  localparam logic [31:0] HALF_TURN = 32'(180 << FRACTION_BITS);
  // A calibration travel below a tenth of a turn is rejected
  localparam logic [31:0] CAL_MIN   = 32'(((360 << FRACTION_BITS) + 9) / 10);

  // Gear ratio after reset, Q16.16 (18.0)
  localparam logic signed [GEAR_W-1:0] GEAR_RST = 32'sd1179648;

  localparam logic signed [COUNT_W-1:0] CNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
  localparam logic signed [COUNT_W-1:0] CNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};
  localparam logic signed [GEAR_W-1:0]  GEAR_MAX = {1'b0, {(GEAR_W-1){1'b1}}};
  localparam logic signed [GEAR_W-1:0]  GEAR_MIN = {1'b1, {(GEAR_W-1){1'b0}}};

  // Request kinds
  localparam logic [3:0] KIND_SAMPLE      = 4'd0;
  localparam logic [3:0] KIND_ZERO_HERE   = 4'd1;
  localparam logic [3:0] KIND_SET_AXLE    = 4'd2;
  localparam logic [3:0] KIND_SYNC_INDEX  = 4'd3;
  localparam logic [3:0] KIND_SYNC_MEAS   = 4'd4;
  localparam logic [3:0] KIND_START_CAL   = 4'd5;
  localparam logic [3:0] KIND_FINISH_CAL  = 4'd6;
  localparam logic [3:0] KIND_SET_OFFSET  = 4'd7;
  localparam logic [3:0] KIND_SET_GEAR    = 4'd8;

  typedef struct packed {
    logic [3:0]                kind;
    logic [RAW_W-1:0]          raw_angle;
    logic signed [COUNT_W-1:0] target_angle;
    logic signed [COUNT_W-1:0] index_angle;
    logic signed [COUNT_W-1:0] measured_center;
    logic signed [COUNT_W-1:0] offset_value;
    logic signed [GEAR_W-1:0]  gear_value;
  } gat_in_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] axle_angle;
    logic signed [COUNT_W-1:0] sensor_angle;
    logic signed [GEAR_W-1:0]  gear_now;
    logic signed [COUNT_W-1:0] zero_now;
    logic                      cal_running;
    logic                      cal_accepted;
  } gat_out_t;

  // Command to the shared multiply/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } gat_cmd_t;

  function automatic logic signed [COUNT_W-1:0] sat_add(
      input logic signed [COUNT_W-1:0] a, input logic signed [COUNT_W-1:0] b);
    logic signed [COUNT_W:0] s;
    s = {a[COUNT_W-1], a} + {b[COUNT_W-1], b};
    if (s[COUNT_W] != s[COUNT_W-1]) begin
      sat_add = s[COUNT_W] ? CNT_MIN : CNT_MAX;
    end else begin
      sat_add = s[COUNT_W-1:0];
    end
  endfunction

  function automatic logic signed [COUNT_W-1:0] sat_sub(
      input logic signed [COUNT_W-1:0] a, input logic signed [COUNT_W-1:0] b);
    logic signed [COUNT_W:0] s;
    s = {a[COUNT_W-1], a} - {b[COUNT_W-1], b};
    if (s[COUNT_W] != s[COUNT_W-1]) begin
      sat_sub = s[COUNT_W] ? CNT_MIN : CNT_MAX;
    end else begin
      sat_sub = s[COUNT_W-1:0];
    end
  endfunction

  // Magnitude; the most negative value maps to 2^(COUNT_W-1)
  function automatic logic [COUNT_W-1:0] mag(input logic signed [COUNT_W-1:0] a);
    mag = a[COUNT_W-1] ? COUNT_W'(-a) : a;
  endfunction

  // Signed value from sign and 64-bit magnitude, saturated to COUNT_W bits
  function automatic logic signed [COUNT_W-1:0] from_mag(input logic neg,
                                                         input logic [63:0] m);
    if (neg) begin
      from_mag = (m >= 64'(CNT_MAX) + 64'd1) ? CNT_MIN : COUNT_W'(-m[COUNT_W-1:0]);
    end else begin
      from_mag = (m > 64'(CNT_MAX)) ? CNT_MAX : m[COUNT_W-1:0];
    end
  endfunction

endpackage

[rtl/gat_iter_unit.sv]
// Shared bit-serial multiply / restoring divide unit of the geared angle tracker.
// Depends on gat_pkg. One add/subtract per cycle: 32 steps multiply, 64 steps divide.
module gat_iter_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  gat_pkg::gat_cmd_t cmd,
  input  logic [63:0]      op_n,   // dividend, or multiplier in [31:0]
  input  logic [47:0]      op_m,   // multiplicand, or divisor in [31:0]
  output logic             done,
  output logic [47:0]      acc,    // product high part / remainder
  output logic [63:0]      sh,     // product low part / quotient
  output logic             rnd     // 2*remainder >= divisor
);
  import gat_pkg::*;

  localparam logic [5:0] MUL_LAST = 6'd31;
  localparam logic [5:0] DIV_LAST = 6'd63;

  logic        busy_r;
  logic        done_r;
  logic        is_div_r;
  logic [5:0]  cnt_r;
  logic [47:0] acc_r;
  logic [63:0] sh_r;
  logic [47:0] opm_r;

  logic [32:0] shifted;
  logic [48:0] op_a;
  logic [48:0] op_b;
  logic [48:0] sum;
  logic [47:0] acc_nxt;
  logic [63:0] sh_nxt;
  logic [5:0]  last;

  // One shared adder: subtract for a divide step, add for a multiply step
  assign shifted = {acc_r[31:0], sh_r[63]};
  assign op_a    = is_div_r ? {16'b0, shifted} : {1'b0, acc_r};
  assign op_b    = is_div_r ? {17'b0, opm_r[31:0]}
                            : (sh_r[0] ? {1'b0, opm_r} : 49'b0);
  assign sum     = is_div_r ? op_a - op_b : op_a + op_b;
  assign last    = is_div_r ? DIV_LAST : MUL_LAST;

  always_comb begin
    if (is_div_r) begin
      acc_nxt = sum[48] ? {15'b0, shifted} : {16'b0, sum[31:0]};
      sh_nxt  = {sh_r[62:0], ~sum[48]};
    end else begin
      acc_nxt = sum[48:1];
      sh_nxt  = {sum[0], sh_r[63:1]};
    end
  end

  // Step sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r   <= 1'b1;
        cnt_r    <= '0;
        is_div_r <= cmd.is_div;
        acc_r    <= '0;
        sh_r     <= cmd.is_div ? op_n : {32'b0, op_n[31:0]};
        opm_r    <= cmd.is_div ? {16'b0, op_m[31:0]} : op_m;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        sh_r  <= sh_nxt;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign acc  = acc_r;
  assign sh   = sh_r;
  assign rnd  = {acc_r[31:0], 1'b0} >= {1'b0, opm_r[31:0]};

endmodule

[rtl/geared_angle_tracker.sv]
// Top level of the geared angle tracker: request sequencer and tracker state.
// Depends on gat_pkg and gat_iter_unit.

// Takes one request at a time and returns one result per request. Simple
// requests (zero here, start cal, set gear, set offset before the first
// sample, finish cal without a run, unused kinds) and a finish cal with too
// little travel do not use the shared unit. A sample, and a set offset after
// the first sample, wait on the 64-step divide of the shared unit, which a
// zero gear skips. Set axle waits on one 32-step multiply. The two sync kinds
// do a 32-step reciprocal multiply for the division by one turn, then the
// 32-step gear multiply. A finish cal does two reciprocal multiplies.
// in_stall is high from acceptance until the result has been loaded into the
// output register; a waiting result does not block the next request from
// entering. The gear register written over cfg_ only feeds the gear value
// taken at reset, which reset itself loads as 18.0 (Q16.16).
module geared_angle_tracker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gat_pkg::gat_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gat_pkg::gat_out_t  out_data,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);
  import gat_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_SAMPLE, S_AXLE_DIFF, S_AXLE_START, S_AXLE_WAIT, S_AXLE_FIN,
    S_NT_DIFF, S_NT_START, S_NT_FIN, S_NT_SAT, S_NT_SUM,
    S_SM_SUB, S_SM_ADD, S_SET_MUL, S_SET_WAIT, S_SET_SAT, S_SET_FIN,
    S_CAL_CHK, S_D45_WAIT, S_D45_MUL, S_D45_SUB, S_D45_FIX, S_CAL_FIN, S_OUT
  } state_t;

  localparam logic signed [18:0] HALF_S = 19'(HALF_TURN);
  localparam logic signed [18:0] FULL_S = 19'(FULL_TURN);

  // One turn is 45 * 2^11 angle units; x / 45 = (x * RECIP45) >> 37,
  // low by at most one for x below 2^37
  localparam int          TURN_SHIFT    = 11;
  localparam logic [47:0] TURN_ODD      = 48'd45;
  localparam logic [47:0] TURN_ODD_HALF = 48'd23;
  localparam logic [31:0] RECIP45       = 32'd3054198966;

  state_t                    state_r;
  gat_in_t                   in_r;
  gat_out_t                  out_r;
  logic                      out_valid_r;
  logic signed [GEAR_W-1:0]  cfg_gear_r;
  logic signed [GEAR_W-1:0]  cfg_gear_nxt;

  logic signed [COUNT_W-1:0] count_r;
  logic [RAW_W-1:0]          prev_r;
  logic signed [COUNT_W-1:0] zero_r;
  logic signed [COUNT_W-1:0] axle_r;
  logic signed [GEAR_W-1:0]  gear_r;
  logic                      seen_r;
  logic                      cal_act_r;
  logic signed [COUNT_W-1:0] origin_r;
  logic                      accepted_r;

  logic signed [COUNT_W-1:0] tmp_r;
  logic signed [COUNT_W-1:0] val_r;
  logic [63:0]               wide_r;
  logic [31:0]               rem_r;
  logic                      rnd_r;
  logic                      neg_r;

  logic [47:0]               div_x_r;
  logic [47:0]               div_q_r;
  logic [47:0]               div_r_r;
  logic                      cal_pass_r;

  gat_cmd_t                  ucmd_r;
  logic [63:0]               uop_n_r;
  logic [47:0]               uop_m_r;
  logic                      u_done;
  logic [47:0]               u_acc;
  logic [63:0]               u_sh;
  logic                      u_rnd;

  logic signed [18:0]        dl0;
  logic signed [18:0]        dl;
  logic [31:0]               gear_mag;
  logic [COUNT_W-1:0]        tmp_mag;
  logic [48:0]               nt_mq;
  logic [47:0]               div_p;
  logic                      div_hi;
  logic [47:0]               div_q_fix;
  logic [47:0]               div_r_fix;
  logic [16:0]               div_rem;

  gat_iter_unit u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (ucmd_r),
    .op_n  (uop_n_r),
    .op_m  (uop_m_r),
    .done  (u_done),
    .acc   (u_acc),
    .sh    (u_sh),
    .rnd   (u_rnd)
  );

  // Configuration register
  assign cfg_gear_nxt = !rst_n ? GEAR_RST : (cfg_we ? cfg_wdata : cfg_gear_r);

  always_ff @(posedge clk) begin
    cfg_gear_r <= cfg_gear_nxt;
  end

  // Raw step folded into half a turn either way
  always_comb begin
    dl0 = $signed({2'b0, in_r.raw_angle}) - $signed({2'b0, prev_r});
    if (dl0 > HALF_S) begin
      dl = dl0 - FULL_S;
    end else if (dl0 < -HALF_S) begin
      dl = dl0 + FULL_S;
    end else begin
      dl = dl0;
    end
  end

  assign gear_mag = gear_r[GEAR_W-1] ? 32'(-gear_r) : gear_r;
  assign tmp_mag  = mag(tmp_r);
  // Nearest multiple of a turn: m - rem, plus a turn when rounding up
  assign nt_mq    = {1'b0, tmp_mag} - {17'b0, rem_r} + (rnd_r ? {17'b0, FULL_TURN} : 49'b0);

  // Divide by 45: q * 45 as shifts, then one correction step
  assign div_p     = (div_q_r << 5) + (div_q_r << 3) + (div_q_r << 2) + div_q_r;
  assign div_hi    = (div_r_r >= TURN_ODD);
  assign div_q_fix = div_q_r + 48'(div_hi);
  assign div_r_fix = div_hi ? div_r_r - TURN_ODD : div_r_r;
  // Remainder of the travel or distance by one full turn
  assign div_rem   = {div_r_fix[5:0], tmp_mag[TURN_SHIFT-1:0]};

  // Sequencer, tracker state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      prev_r      <= '0;
      zero_r      <= '0;
      axle_r      <= '0;
      gear_r      <= cfg_gear_nxt;
      seen_r      <= 1'b0;
      cal_act_r   <= 1'b0;
      origin_r    <= '0;
      accepted_r  <= 1'b0;
      ucmd_r      <= '0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_r    <= in_data;
            state_r <= S_EXEC;
          end
        end
        // Dispatch on the request kind
        S_EXEC: begin
          accepted_r <= 1'b0;
          unique case (in_r.kind)
            KIND_SAMPLE: begin
              tmp_r   <= COUNT_W'(dl);
              state_r <= S_SAMPLE;
            end
            KIND_ZERO_HERE: begin
              zero_r  <= count_r;
              axle_r  <= '0;
              state_r <= S_OUT;
            end
            KIND_SET_AXLE: begin
              tmp_r   <= in_r.target_angle;
              state_r <= S_SET_MUL;
            end
            KIND_SYNC_INDEX: begin
              val_r   <= axle_r;
              state_r <= S_NT_DIFF;
            end
            KIND_SYNC_MEAS: begin
              val_r   <= in_r.measured_center;
              state_r <= S_NT_DIFF;
            end
            KIND_START_CAL: begin
              origin_r  <= count_r;
              cal_act_r <= 1'b1;
              state_r   <= S_OUT;
            end
            KIND_FINISH_CAL: begin
              if (cal_act_r) begin
                tmp_r     <= sat_sub(count_r, origin_r);
                cal_act_r <= 1'b0;
                state_r   <= S_CAL_CHK;
              end else begin
                state_r <= S_OUT;
              end
            end
            KIND_SET_OFFSET: begin
              zero_r  <= in_r.offset_value;
              state_r <= seen_r ? S_AXLE_DIFF : S_OUT;
            end
            KIND_SET_GEAR: begin
              gear_r  <= in_r.gear_value;
              state_r <= S_OUT;
            end
            default: begin
              state_r <= S_OUT;
            end
          endcase
        end
        // Sample: first one loads the count, later ones add the folded step
        S_SAMPLE: begin
          count_r <= seen_r ? sat_add(count_r, tmp_r) : COUNT_W'(in_r.raw_angle);
          seen_r  <= 1'b1;
          prev_r  <= in_r.raw_angle;
          state_r <= S_AXLE_DIFF;
        end
        // Axle = (count - zero) / gear
        S_AXLE_DIFF: begin
          tmp_r   <= sat_sub(count_r, zero_r);
          state_r <= S_AXLE_START;
        end
        S_AXLE_START: begin
          if (gear_r == '0) begin
            axle_r  <= (tmp_r == '0) ? '0 : (tmp_r[COUNT_W-1] ? CNT_MIN : CNT_MAX);
            state_r <= S_OUT;
          end else begin
            uop_n_r       <= {tmp_mag, 16'b0};
            uop_m_r       <= {16'b0, gear_mag};
            ucmd_r.start  <= 1'b1;
            ucmd_r.is_div <= 1'b1;
            neg_r         <= tmp_r[COUNT_W-1] ^ gear_r[GEAR_W-1];
            state_r       <= S_AXLE_WAIT;
          end
        end
        S_AXLE_WAIT: begin
          ucmd_r.start <= 1'b0;
          if (u_done) begin
            wide_r  <= u_sh + 64'(u_rnd);
            state_r <= S_AXLE_FIN;
          end
        end
        S_AXLE_FIN: begin
          axle_r  <= from_mag(neg_r, wide_r);
          state_r <= S_OUT;
        end
        // Nearest turn to val_r, aligned on the index angle
        S_NT_DIFF: begin
          tmp_r   <= sat_sub(val_r, in_r.index_angle);
          state_r <= S_NT_START;
        end
        S_NT_START: begin
          div_x_r       <= tmp_mag >> TURN_SHIFT;
          uop_m_r       <= tmp_mag >> TURN_SHIFT;
          uop_n_r       <= {32'b0, RECIP45};
          ucmd_r.start  <= 1'b1;
          ucmd_r.is_div <= 1'b0;
          neg_r         <= tmp_r[COUNT_W-1];
          state_r       <= S_D45_WAIT;
        end
        S_NT_FIN: begin
          wide_r  <= 64'(nt_mq);
          state_r <= S_NT_SAT;
        end
        S_NT_SAT: begin
          val_r   <= from_mag(neg_r, wide_r);
          state_r <= S_NT_SUM;
        end
        S_NT_SUM: begin
          tmp_r   <= sat_add(in_r.index_angle, val_r);
          state_r <= (in_r.kind == KIND_SYNC_INDEX) ? S_SET_MUL : S_SM_SUB;
        end
        // Sync measured: axle + (turn - measured)
        S_SM_SUB: begin
          tmp_r   <= sat_sub(tmp_r, in_r.measured_center);
          state_r <= S_SM_ADD;
        end
        S_SM_ADD: begin
          tmp_r   <= sat_add(axle_r, tmp_r);
          state_r <= S_SET_MUL;
        end
        // Set axle to tmp_r: zero = count - round(deg * gear)
        S_SET_MUL: begin
          uop_n_r       <= {32'b0, gear_mag};
          uop_m_r       <= tmp_mag;
          ucmd_r.start  <= 1'b1;
          ucmd_r.is_div <= 1'b0;
          neg_r         <= tmp_r[COUNT_W-1] ^ gear_r[GEAR_W-1];
          state_r       <= S_SET_WAIT;
        end
        S_SET_WAIT: begin
          ucmd_r.start <= 1'b0;
          if (u_done) begin
            wide_r  <= {u_acc, u_sh[63:48]} + 64'(u_sh[47]);
            state_r <= S_SET_SAT;
          end
        end
        S_SET_SAT: begin
          val_r   <= from_mag(neg_r, wide_r);
          state_r <= S_SET_FIN;
        end
        S_SET_FIN: begin
          zero_r  <= sat_sub(count_r, val_r);
          axle_r  <= tmp_r;
          state_r <= S_OUT;
        end
        // Finish calibration: gear = travel / one turn in Q16.16
        S_CAL_CHK: begin
          if (tmp_mag < COUNT_W'(CAL_MIN)) begin
            state_r <= S_OUT;
          end else begin
            div_x_r       <= tmp_mag >> TURN_SHIFT;
            uop_m_r       <= tmp_mag >> TURN_SHIFT;
            uop_n_r       <= {32'b0, RECIP45};
            ucmd_r.start  <= 1'b1;
            ucmd_r.is_div <= 1'b0;
            neg_r         <= tmp_r[COUNT_W-1];
            cal_pass_r    <= 1'b0;
            state_r       <= S_D45_WAIT;
          end
        end
        // Divide div_x_r by 45: reciprocal estimate, then remainder and fix
        S_D45_WAIT: begin
          ucmd_r.start <= 1'b0;
          if (u_done) begin
            div_q_r <= {5'b0, u_acc[47:5]};
            state_r <= S_D45_MUL;
          end
        end
        S_D45_MUL: begin
          div_r_r <= div_p;
          state_r <= S_D45_SUB;
        end
        S_D45_SUB: begin
          div_r_r <= div_x_r - div_r_r;
          state_r <= S_D45_FIX;
        end
        S_D45_FIX: begin
          priority if (in_r.kind != KIND_FINISH_CAL) begin
            // Sync: remainder by one turn and its rounding
            rem_r   <= 32'(div_rem);
            rnd_r   <= ({div_rem, 1'b0} >= 18'(FULL_TURN));
            state_r <= S_NT_FIN;
          end else if (!cal_pass_r) begin
            // Whole turns, then the fraction: remainder * 2^16 / one turn
            wide_r        <= {div_q_fix, 16'b0};
            div_x_r       <= {26'b0, div_rem, 5'b0};
            uop_m_r       <= {26'b0, div_rem, 5'b0};
            uop_n_r       <= {32'b0, RECIP45};
            ucmd_r.start  <= 1'b1;
            ucmd_r.is_div <= 1'b0;
            cal_pass_r    <= 1'b1;
            state_r       <= S_D45_WAIT;
          end else begin
            wide_r  <= wide_r + 64'(div_q_fix) + 64'(div_r_fix >= TURN_ODD_HALF);
            state_r <= S_CAL_FIN;
          end
        end
        S_CAL_FIN: begin
          if (neg_r) begin
            gear_r <= (wide_r >= 64'(GEAR_MAX) + 64'd1) ? GEAR_MIN : 32'(-wide_r[31:0]);
          end else begin
            gear_r <= (wide_r > 64'(GEAR_MAX)) ? GEAR_MAX : wide_r[31:0];
          end
          accepted_r <= 1'b1;
          state_r    <= S_OUT;
        end
        // Load the result once the output register is free
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_r.axle_angle   <= axle_r;
            out_r.sensor_angle <= sat_sub(count_r, zero_r);
            out_r.gear_now     <= gear_r;
            out_r.zero_now     <= zero_r;
            out_r.cal_running  <= cal_act_r;
            out_r.cal_accepted <= accepted_r;
            out_valid_r        <= 1'b1;
            state_r            <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[tb/geared_angle_tracker_tb.sv]
// Self-checking testbench for geared_angle_tracker: directed and random requests,
// checked against an in-bench predictor of the tracker. Depends on gat_pkg and the RTL.
module geared_angle_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gat_pkg::*;

  localparam longint CMAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint CMIN = -CMAX - 1;
  localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64_MIN = -I64_MAX - 1;
  localparam longint TURN = longint'(FULL_TURN);
  localparam longint HALF = longint'(HALF_TURN);
  localparam logic [3:0] KIND_UNUSED_TOP = 4'd15;
  localparam int SETTLE = 150;
  localparam int LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  gat_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gat_out_t out_data;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  geared_angle_tracker DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tracker state mirror
  longint turn_cnt, prev_raw, zero_ofs, axle, gear, cal_base;
  bit seen, cal_on;

  gat_out_t expected_readings[$];
  int mismatches = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;
  logic [16:0] last_raw = '0;

  function automatic longint clamp48(longint v);
    return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
  endfunction

  function automatic logic [63:0] umag(longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic longint signed_of(bit neg, logic [63:0] m);
    if (neg) return (m >= 64'h8000_0000_0000_0000) ? I64_MIN : -$signed(m);
    return (m > 64'h7FFF_FFFF_FFFF_FFFF) ? I64_MAX : $signed(m);
  endfunction

  // (m << 16) / d, rounded half up, saturating
  function automatic logic [63:0] q16_div(logic [63:0] m, logic [63:0] d);
    logic [63:0] q, r, f, rr;
    q = m / d;
    r = m % d;
    if (q >= (64'hFFFF_FFFF_FFFF_FFFF >> 16) - 64'd1) return '1;
    f = (r << 16) / d;
    rr = (r << 16) % d;
    if ((rr << 1) >= d) f = f + 64'd1;
    return (q << 16) + f;
  endfunction

  // angle times Q16.16 gear, rounded half away from zero
  function automatic longint gear_mul(longint deg, longint g);
    logic [63:0] a, gm, hi, lo, m;
    bit neg;
    a = umag(deg);
    gm = umag(g);
    hi = a >> 16;
    lo = a & 64'hFFFF;
    neg = (deg < 0) != (g < 0);
    if (gm != 0 && hi > 64'hFFFF_FFFF_FFFF_FFFF / gm) return neg ? CMIN : CMAX;
    m = hi * gm;
    lo = (lo * gm + 64'h8000) >> 16;
    m = (m > 64'hFFFF_FFFF_FFFF_FFFF - lo) ? '1 : m + lo;
    return clamp48(signed_of(neg, m));
  endfunction

  function automatic longint axle_from(longint diff);
    if (gear == 0) begin
      if (diff == 0) return 0;
      return diff < 0 ? CMIN : CMAX;
    end
    return clamp48(signed_of((diff < 0) != (gear < 0), q16_div(umag(diff), umag(gear))));
  endfunction

  function automatic void place_axle(longint deg);
    deg = clamp48(deg);
    zero_ofs = clamp48(turn_cnt - gear_mul(deg, gear));
    axle = deg;
  endfunction

  // index plus the whole number of turns nearest to from
  function automatic longint snap_turn(longint from, longint idx);
    longint d;
    logic [63:0] m, q, r;
    d = clamp48(from - idx);
    m = umag(d);
    q = m / 64'(TURN);
    r = m % 64'(TURN);
    if ((r << 1) >= 64'(TURN)) q = q + 64'd1;
    return clamp48(idx + clamp48(signed_of(d < 0, q * 64'(TURN))));
  endfunction

  function automatic void clear_tracker();
    turn_cnt = 0; prev_raw = 0; zero_ofs = 0; axle = 0;
    gear = longint'(GEAR_RST); seen = 0; cal_on = 0; cal_base = 0;
  endfunction

  // Advance the mirror by one request and return the reading it produces
  function automatic gat_out_t track_request(gat_in_t r);
    gat_out_t o;
    longint delta, t, meas, trav;
    logic [63:0] m, q;
    bit accepted;
    accepted = 0;
    case (r.kind)
      KIND_SAMPLE: begin
        if (!seen) begin
          turn_cnt = longint'(r.raw_angle);
          seen = 1;
        end else begin
          delta = longint'(r.raw_angle) - prev_raw;
          if (delta > HALF) delta -= TURN;
          if (delta < -HALF) delta += TURN;
          turn_cnt = clamp48(turn_cnt + delta);
        end
        prev_raw = longint'(r.raw_angle);
        axle = axle_from(clamp48(turn_cnt - zero_ofs));
      end
      KIND_ZERO_HERE: begin
        zero_ofs = turn_cnt;
        axle = 0;
      end
      KIND_SET_AXLE: place_axle(longint'(r.target_angle));
      KIND_SYNC_INDEX: place_axle(snap_turn(axle, longint'(r.index_angle)));
      KIND_SYNC_MEAS: begin
        meas = longint'(r.measured_center);
        t = snap_turn(meas, longint'(r.index_angle));
        place_axle(clamp48(axle + clamp48(t - meas)));
      end
      KIND_START_CAL: begin
        cal_base = turn_cnt;
        cal_on = 1;
      end
      KIND_FINISH_CAL: begin
        if (cal_on) begin
          trav = clamp48(turn_cnt - cal_base);
          m = umag(trav);
          cal_on = 0;
          if (!(m < 64'(TURN) && m * 10 < 64'(TURN))) begin
            q = q16_div(m, 64'(TURN));
            if (trav < 0) gear = (q >= 64'h8000_0000) ? -64'sd2147483648 : -longint'(q);
            else gear = (q > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(q);
            accepted = 1;
          end
        end
      end
      KIND_SET_OFFSET: begin
        zero_ofs = longint'(r.offset_value);
        if (seen) axle = axle_from(clamp48(turn_cnt - zero_ofs));
      end
      KIND_SET_GEAR: gear = longint'(r.gear_value);
      default: ;
    endcase
    o.axle_angle = axle[47:0];
    o.sensor_angle = 48'(clamp48(turn_cnt - zero_ofs));
    o.gear_now = gear[31:0];
    o.zero_now = zero_ofs[47:0];
    o.cal_running = cal_on;
    o.cal_accepted = accepted;
    return o;
  endfunction

  // Result checker
  always @(posedge clk) begin
    gat_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reading: %p", out_data);
      end else begin
        want = expected_readings.pop_front();
        if (out_data.axle_angle !== want.axle_angle ||
            out_data.sensor_angle !== want.sensor_angle ||
            out_data.gear_now !== want.gear_now ||
            out_data.zero_now !== want.zero_now ||
            out_data.cal_running !== want.cal_running ||
            out_data.cal_accepted !== want.cal_accepted) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch axle exp %0d got %0d | sensor exp %0d got %0d",
                     want.axle_angle, out_data.axle_angle,
                     want.sensor_angle, out_data.sensor_angle);
            $display("  gear exp %0d got %0d | zero exp %0d got %0d | cal exp %b%b got %b%b",
                     want.gear_now, out_data.gear_now, want.zero_now, out_data.zero_now,
                     want.cal_running, want.cal_accepted,
                     out_data.cal_running, out_data.cal_accepted);
          end
        end
      end
    end
  end

  // Receiver stall: random, or a counted hold-off when requested
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 38);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("geared_angle_tracker_tb: done, errors");
      $finish;
    end
  end

  function automatic logic signed [47:0] rand48();
    case ($urandom_range(0, 4))
      0: return 48'({$urandom, $urandom});
      1: return 48'($signed($urandom_range(0, 200000)) - 100000);
      2: return CNT_MAX;
      3: return CNT_MIN;
      default: return 48'($signed({$urandom} >> 1) - 64'sd1073741824);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_gear();
    logic signed [31:0] g;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return '0;
      default: begin
        g = $urandom_range(1 << 12, 1 << 22);
        return $urandom_range(1) ? -g : g;
      end
    endcase
  endfunction

  function automatic gat_in_t make_req(logic [3:0] k);
    gat_in_t r;
    r.kind = k;
    r.raw_angle = 17'($urandom_range(0, 92159));
    r.target_angle = rand48();
    r.index_angle = rand48();
    r.measured_center = rand48();
    r.offset_value = rand48();
    r.gear_value = rand_gear();
    return r;
  endfunction

  task automatic send_req(gat_in_t r);
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    expected_readings.push_back(track_request(r));
    if (r.kind == KIND_SAMPLE) last_raw = r.raw_angle;
    if (idle_on && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // A sample stepped from the last raw angle, wrapped into one turn
  task automatic send_step(int step);
    gat_in_t r;
    int v;
    r = make_req(KIND_SAMPLE);
    v = int'(last_raw) + step;
    if (v < 0) v += 92160;
    if (v > 92159) v -= 92160;
    r.raw_angle = 17'(v);
    send_req(r);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_gear_cfg(logic [31:0] v);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed();
    gat_in_t r;
    // set offset before any sample leaves the axle alone
    r = make_req(KIND_SET_OFFSET); r.offset_value = 48'sd1000; send_req(r);
    r = make_req(KIND_FINISH_CAL); send_req(r);
    r = make_req(KIND_SAMPLE); r.raw_angle = 17'd92159; send_req(r);
    r = make_req(KIND_SAMPLE); r.raw_angle = 17'd0; send_req(r);
    r = make_req(KIND_SAMPLE); r.raw_angle = 17'h1FFFF; send_req(r);
    r = make_req(KIND_SAMPLE); r.raw_angle = 17'd46080; send_req(r);
    r = make_req(KIND_ZERO_HERE); send_req(r);
    r = make_req(KIND_SET_AXLE); r.target_angle = CNT_MAX; send_req(r);
    r = make_req(KIND_SET_AXLE); r.target_angle = CNT_MIN; send_req(r);
    r = make_req(KIND_SYNC_INDEX); r.index_angle = 48'sd46080; send_req(r);
    r = make_req(KIND_SYNC_INDEX); r.index_angle = CNT_MIN; send_req(r);
    r = make_req(KIND_SYNC_MEAS); r.index_angle = CNT_MAX;
    r.measured_center = CNT_MIN; send_req(r);
    // small travel is rejected
    r = make_req(KIND_START_CAL); send_req(r);
    send_step(500);
    r = make_req(KIND_FINISH_CAL); send_req(r);
    // one full turn backwards is accepted
    r = make_req(KIND_START_CAL); send_req(r);
    repeat (4) send_step(-23040);
    r = make_req(KIND_FINISH_CAL); send_req(r);
    r = make_req(KIND_SET_GEAR); r.gear_value = '0; send_req(r);
    send_step(100);
    r = make_req(KIND_SET_GEAR); r.gear_value = GEAR_MIN; send_req(r);
    send_step(-300);
    r = make_req(KIND_SET_GEAR); r.gear_value = GEAR_MAX; send_req(r);
    r = make_req(KIND_SET_OFFSET); r.offset_value = CNT_MIN; send_req(r);
    r = make_req(KIND_UNUSED_TOP); send_req(r);
  endtask

  task automatic test_random(int n);
    int dir, len;
    gat_in_t r;
    while (n > 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          send_step($urandom_range(0, 4000) - 2000);
          n--;
        end
        5: begin
          // calibration run with steady travel
          dir = $urandom_range(1) ? 1 : -1;
          len = $urandom_range(2, 12);
          send_req(make_req(KIND_START_CAL));
          repeat (len) send_step(dir * $urandom_range(200, 12000));
          send_req(make_req(KIND_FINISH_CAL));
          n -= len + 2;
        end
        6: begin
          r = make_req(KIND_SAMPLE);
          r.raw_angle = 17'($urandom_range(0, 131071));
          send_req(r);
          n--;
        end
        default: begin
          send_req(make_req(4'($urandom_range(0, 15))));
          n--;
        end
      endcase
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (6) send_step($urandom_range(0, 2000) - 1000);
  endtask

  task automatic test_sender_pause();
    send_req(make_req(KIND_SET_AXLE));
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (5) send_step(700);
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    test_random(60);
    idle_on = 1'b1;
  endtask

  initial begin
    bit clean;
    clear_tracker();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_gear_cfg(32'h7FFF_FFFF);
    test_directed();
    write_gear_cfg(32'h8000_0000);
    test_random(230);
    test_backpressure();
    write_gear_cfg(32'h0000_0000);
    test_sender_pause();
    test_no_idle();
    write_gear_cfg(GEAR_RST);
    test_random(60);
    wait_drain();
    clean = (mismatches == 0) && (expected_readings.size() == 0);
    if (clean) begin
      $display("geared_angle_tracker_tb: done, clean");
    end else begin
      $display("geared_angle_tracker_tb: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/gat_pkg.sv
rtl/gat_iter_unit.sv
rtl/geared_angle_tracker.sv
tb/geared_angle_tracker_tb.sv
